FILE: rtl/jtr_pkg.sv
// Package for the JSON text reformatter: character codes, item kinds,
// controller states and the command/status structs between controller
// and datapath. No dependencies.
package jtr_pkg;

    // Default nesting limit
    localparam int MAX_DEPTH_DEF = 16;

    // Character codes
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // What one input byte turns into
    typedef enum logic [2:0] {
        K_NONE  = 3'd0,   // dropped whitespace
        K_PLAIN = 3'd1,   // the byte alone
        K_OPEN  = 3'd2,   // byte, newline, indent
        K_CLOSE = 3'd3,   // newline, indent, byte
        K_COMMA = 3'd4,   // byte, newline, indent
        K_COLON = 3'd5    // byte, one space
    } t_kind;

    // Which result the datapath loads into the output register
    typedef enum logic [1:0] {
        SEL_CHAR   = 2'd0,
        SEL_NL     = 2'd1,
        SEL_SPACE  = 2'd2,
        SEL_STATUS = 2'd3
    } t_sel;

    // Controller states
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHAR   = 6'b000010,
        S_NL     = 6'b000100,
        S_SPACE  = 6'b001000,
        S_STATUS = 6'b010000,
        S_SPARE  = 6'b100000
    } t_state;

    typedef struct packed {
        logic load;      // take the input byte and update the parse state
        logic emit;      // load a result into the output register
        t_sel sel;       // which result
        logic end_run;   // result closes the run of this byte
        logic cnt_dec;   // count down one indent space
        logic clear;     // return parse state to reset
    } t_cmd;

    typedef struct packed {
        t_kind in_kind;  // kind of the byte on the input
        logic  in_last;
        t_kind kind;     // kind of the byte being emitted
        logic  last;
        logic  cnt_zero;
        logic  cnt_one;
        logic  out_free; // output register can take a result this cycle
        logic  clean;    // parse state at reset values
    } t_sts;

endpackage

FILE: rtl/jtr_in_if.sv
// Input channel of the JSON text reformatter: one byte and its last mark.
// No dependencies.
interface jtr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       last_char;

    modport source (output valid, output in_char, output last_char, input ready);
    modport sink   (input valid, input in_char, input last_char, output ready);
endinterface

FILE: rtl/jtr_out_if.sv
// Output channel of the JSON text reformatter: one output byte or status item.
// No dependencies.
interface jtr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_present;
    logic       end_of_run;
    logic       end_of_text;
    logic       json_ok;

    modport source (output valid, output out_char, output char_present,
                    output end_of_run, output end_of_text, output json_ok, input ready);
    modport sink   (input valid, input out_char, input char_present,
                    input end_of_run, input end_of_text, input json_ok, output ready);
endinterface

FILE: rtl/jtr_datapath.sv
// Datapath of the JSON text reformatter: parse state, byte decode, indent
// counter, mode register and output register. Depends on jtr_pkg.
module jtr_datapath #(
    parameter int MAX_DEPTH = jtr_pkg::MAX_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_data,
    input  logic [7:0]    i_in_char,
    input  logic          i_last_char,
    input  logic          i_out_ready,
    input  jtr_pkg::t_cmd i_cmd,
    output jtr_pkg::t_sts o_sts,
    output logic          o_out_valid,
    output logic [7:0]    o_out_char,
    output logic          o_char_present,
    output logic          o_end_of_run,
    output logic          o_end_of_text,
    output logic          o_json_ok
);
    import jtr_pkg::*;

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int CW = $clog2(2 * MAX_DEPTH + 1);

    logic          r_minify;
    logic          r_str, n_str;
    logic          r_esc, n_esc;
    logic [DW-1:0] r_depth, n_depth;
    logic          r_err, n_err;
    logic [7:0]    r_char;
    logic          r_last;
    t_kind         r_kind, w_kind;
    logic [CW-1:0] r_cnt, w_cnt_init;
    logic          r_out_valid;
    logic [7:0]    r_out_char;
    logic          r_out_present, r_out_end_run, r_out_eot, r_out_ok;
    logic          w_ws;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minify <= 1'b0;
        end else if (i_cfg_we) begin
            r_minify <= i_cfg_data;
        end
    end

    assign w_ws = (i_in_char == CH_SPACE) || (i_in_char == CH_TAB) ||
                  (i_in_char == CH_LF) || (i_in_char == CH_CR);

    // Decode the input byte and work out the next parse state
    always_comb begin
        n_str   = r_str;
        n_esc   = r_esc;
        n_depth = r_depth;
        n_err   = r_err;
        w_kind  = K_NONE;
        priority if (r_esc) begin
            w_kind = K_PLAIN;
            n_esc  = 1'b0;
        end else if (i_in_char == CH_BSLASH && r_str) begin
            w_kind = K_PLAIN;
            n_esc  = 1'b1;
        end else if (i_in_char == CH_QUOTE) begin
            w_kind = K_PLAIN;
            n_str  = ~r_str;
        end else if (r_str) begin
            w_kind = K_PLAIN;
        end else if (w_ws) begin
            w_kind = K_NONE;
        end else if (i_in_char == CH_LBRACE || i_in_char == CH_LBRACK) begin
            if (r_depth < DW'(MAX_DEPTH)) begin
                n_depth = r_depth + DW'(1);
            end else begin
                n_err = 1'b1;
            end
            w_kind = r_minify ? K_PLAIN : K_OPEN;
        end else if (i_in_char == CH_RBRACE || i_in_char == CH_RBRACK) begin
            if (r_depth != '0) begin
                n_depth = r_depth - DW'(1);
            end else begin
                n_err = 1'b1;
            end
            w_kind = r_minify ? K_PLAIN : K_CLOSE;
        end else if (i_in_char == CH_COMMA) begin
            w_kind = r_minify ? K_PLAIN : K_COMMA;
        end else if (i_in_char == CH_COLON) begin
            w_kind = r_minify ? K_PLAIN : K_COLON;
        end else begin
            w_kind = K_PLAIN;
        end
    end

    // Spaces that follow the newline, or the one after a colon
    always_comb begin
        if (w_kind == K_COLON) begin
            w_cnt_init = CW'(1);
        end else begin
            w_cnt_init = CW'({n_depth, 1'b0});
        end
    end

    // Parse state: update on a taken byte, clear after the status item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_str   <= 1'b0;
            r_esc   <= 1'b0;
            r_depth <= '0;
            r_err   <= 1'b0;
        end else if (i_cmd.load) begin
            r_str   <= n_str;
            r_esc   <= n_esc;
            r_depth <= n_depth;
            r_err   <= n_err;
        end
    end

    // Hold the byte and its plan while its results go out
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_char <= i_in_char;
            r_last <= i_last_char;
            r_kind <= w_kind;
            r_cnt  <= w_cnt_init;
        end else if (i_cmd.cnt_dec) begin
            r_cnt  <= r_cnt - CW'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_end_run <= i_cmd.end_run;
            unique case (i_cmd.sel)
                SEL_CHAR: begin
                    r_out_char    <= r_char;
                    r_out_present <= 1'b1;
                    r_out_eot     <= 1'b0;
                    r_out_ok      <= 1'b0;
                end
                SEL_NL: begin
                    r_out_char    <= CH_LF;
                    r_out_present <= 1'b1;
                    r_out_eot     <= 1'b0;
                    r_out_ok      <= 1'b0;
                end
                SEL_SPACE: begin
                    r_out_char    <= CH_SPACE;
                    r_out_present <= 1'b1;
                    r_out_eot     <= 1'b0;
                    r_out_ok      <= 1'b0;
                end
                default: begin
                    r_out_char    <= 8'h00;
                    r_out_present <= 1'b0;
                    r_out_eot     <= 1'b1;
                    r_out_ok      <= !r_str && (r_depth == '0) && !r_err;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_char     = r_out_char;
    assign o_char_present = r_out_present;
    assign o_end_of_run   = r_out_end_run;
    assign o_end_of_text  = r_out_eot;
    assign o_json_ok      = r_out_ok;

    // Status to the controller
    assign o_sts.in_kind  = w_kind;
    assign o_sts.in_last  = i_last_char;
    assign o_sts.kind     = r_kind;
    assign o_sts.last     = r_last;
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.cnt_one  = (r_cnt == CW'(1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.clean    = !r_str && !r_esc && (r_depth == '0) && !r_err;

endmodule

FILE: rtl/jtr_ctrl.sv
// Controller of the JSON text reformatter: sequences the results of one
// byte (byte, newline, indent spaces, status). Depends on jtr_pkg.
module jtr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  jtr_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output jtr_pkg::t_cmd o_cmd
);
    import jtr_pkg::*;

    t_state r_state, n_state;
    t_state w_done;
    logic   w_tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Where a byte goes once its last character is out
    assign w_done = i_sts.last ? S_STATUS : S_IDLE;
    // A close still owes its own byte after the indent
    assign w_tail = (i_sts.kind == K_CLOSE);

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd.load    = 1'b0;
        o_cmd.emit    = 1'b0;
        o_cmd.sel     = SEL_CHAR;
        o_cmd.end_run = 1'b0;
        o_cmd.cnt_dec = 1'b0;
        o_cmd.clear   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    priority case (i_sts.in_kind)
                        K_NONE:  n_state = i_sts.in_last ? S_STATUS : S_IDLE;
                        K_CLOSE: n_state = S_NL;
                        default: n_state = S_CHAR;
                    endcase
                end
            end
            S_CHAR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_CHAR;
                    priority case (i_sts.kind)
                        K_OPEN, K_COMMA: n_state = S_NL;
                        K_COLON:         n_state = S_SPACE;
                        default: begin
                            n_state       = w_done;
                            o_cmd.end_run = !i_sts.last;
                        end
                    endcase
                end
            end
            S_NL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_NL;
                    if (!i_sts.cnt_zero) begin
                        n_state = S_SPACE;
                    end else if (w_tail) begin
                        n_state = S_CHAR;
                    end else begin
                        n_state       = w_done;
                        o_cmd.end_run = !i_sts.last;
                    end
                end
            end
            S_SPACE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.sel     = SEL_SPACE;
                    o_cmd.cnt_dec = 1'b1;
                    if (!i_sts.cnt_one) begin
                        n_state = S_SPACE;
                    end else if (w_tail) begin
                        n_state = S_CHAR;
                    end else begin
                        n_state       = w_done;
                        o_cmd.end_run = !i_sts.last;
                    end
                end
            end
            S_STATUS: begin
                if (i_sts.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.sel     = SEL_STATUS;
                    o_cmd.end_run = 1'b1;
                    o_cmd.clear   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/json_text_reformatter.sv
// JSON text reformatter, top level: joins controller and datapath to the
// input, output and mode-register ports. Depends on jtr_pkg, jtr_in_if,
// jtr_out_if, jtr_ctrl and jtr_datapath.
//
// Usage: JSON text enters on i_in one byte per transaction, with last_char
// on the final byte. Results leave on o_out, one byte or status item per
// transaction; end_of_run marks the last result of a byte, and the final
// byte adds a status item with end_of_text and json_ok. i_cfg_we writes
// minify_mode (0 pretty-print, 1 strip whitespace only); the user must
// write it only while idle, which the block itself does not enforce.
// Timing: a byte is taken in the idle state, then its results are loaded
// into the output register one at a time: none for dropped whitespace,
// the byte alone for a plain byte, and the byte with a newline and indent
// spaces, sent by the indent-space loop of the controller, for a brace,
// bracket or comma. Reset (synchronous, active low) clears the parse
// state, the output valid flag and the mode. A stalled receiver holds the
// output register and the sequencer; no input is taken until the last
// result of a byte has been loaded into the output register.
module json_text_reformatter #(
    parameter int MAX_DEPTH = jtr_pkg::MAX_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    jtr_in_if.sink    i_in,
    jtr_out_if.source o_out
);
    import jtr_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    // Sequencer
    jtr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // Parse state and output register
    jtr_datapath #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_char      (i_in.in_char),
        .i_last_char    (i_in.last_char),
        .i_out_ready    (o_out.ready),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_out_valid    (o_out.valid),
        .o_out_char     (o_out.out_char),
        .o_char_present (o_out.char_present),
        .o_end_of_run   (o_out.end_of_run),
        .o_end_of_text  (o_out.end_of_text),
        .o_json_ok      (o_out.json_ok)
    );

    assign i_in.ready = w_in_ready;

`ifndef SYNTHESIS
    // A result is loaded only when the output register is free
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!o_out.valid || o_out.ready))
        else $error("result loaded over a waiting result");

    // The status item leaves the parse state at reset values
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear |=> w_sts.clean)
        else $error("parse state not cleared after status item");

    // A status item closes its run and carries no byte
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.end_of_text) |-> (o_out.end_of_run && !o_out.char_present))
        else $error("malformed status item");

    // No byte is taken while results are still being produced
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> !w_cmd.emit)
        else $error("byte taken during emission");
`endif

endmodule
